@@ design/sbpe_pkg.sv @@
// Shared types, codes and sizes of the servo bus packet engine.
package sbpe_pkg;

   // Input item modes, carried on req_tuser.
   localparam logic [1:0] MODE_START = 2'd0;
   localparam logic [1:0] MODE_PARAM = 2'd1;
   localparam logic [1:0] MODE_RX    = 2'd2;
   localparam logic [1:0] MODE_TICK  = 2'd3;

   // Result item kinds, carried on rsp_tuser.
   localparam logic [1:0] KIND_TX   = 2'd0;
   localparam logic [1:0] KIND_BODY = 2'd1;
   localparam logic [1:0] KIND_DONE = 2'd2;

   // Transaction outcomes.
   localparam logic [1:0] OUTCOME_NO_REPLY = 2'd0;
   localparam logic [1:0] OUTCOME_REPLY    = 2'd1;
   localparam logic [1:0] OUTCOME_BAD_HDR  = 2'd2;
   localparam logic [1:0] OUTCOME_TIMEOUT  = 2'd3;

   // Configuration register indexes.
   localparam logic CSR_BROADCAST_ID  = 1'b0;
   localparam logic CSR_TIMEOUT_TICKS = 1'b1;

   localparam logic [7:0]  SYNC_BYTE        = 8'hFF;
   localparam logic [7:0]  LEN_OVERHEAD     = 8'd2;
   localparam logic [7:0]  BROADCAST_RESET  = 8'd254;
   localparam logic [15:0] TIMEOUT_RESET    = 16'd20;
   localparam logic [15:0] IDLE_TICKS_MAX   = 16'hFFFF;
   localparam logic [2:0]  HDR_LAST_IDX     = 3'd4;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // Bit positions of the parts of one job, in emission order.
   localparam int PART_HDR  = 0;
   localparam int PART_DATA = 1;
   localparam int PART_CKS  = 2;
   localparam int PART_DONE = 3;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_PARAMS,
      PH_HEADER,
      PH_BODY
   } phase_type;

   // One classified input item: the result items it causes, in compact form.
   typedef struct packed {
      logic       hdr_en;
      logic [7:0] hdr_id;
      logic [7:0] hdr_len;
      logic [7:0] hdr_inst;
      logic       data_en;
      logic [1:0] data_kind;
      logic [7:0] data_byte;
      logic       data_last;
      logic       cks_en;
      logic [7:0] cks;
      logic       done_en;
      logic [1:0] outcome;
      logic [7:0] reply_len;
   } job_type;

endpackage

@@ design/sbpe_front.sv @@
// Front end: accepts input items, tracks the transaction and classifies items into jobs.
module sbpe_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  logic [1:0]          mode,
   input  logic [7:0]          target_id,
   input  logic [7:0]          instruction,
   input  logic [7:0]          param_count,
   input  logic                want_reply,
   input  logic [7:0]          data_byte,
   input  logic                csr_wr_en,
   input  logic                csr_index,
   input  logic [15:0]         csr_wdata,
   output logic                push,
   output sbpe_pkg::job_type   job
);

   sbpe_pkg::phase_type phase_ff, phase_in;
   logic [7:0]  sum_ff, sum_in;
   logic [7:0]  params_left_ff, params_left_in;
   logic [7:0]  current_id_ff, current_id_in;
   logic        reply_exp_ff, reply_exp_in;
   logic [1:0]  hdr_idx_ff, hdr_idx_in;
   logic        hdr_good_ff, hdr_good_in;
   logic [7:0]  body_left_ff, body_left_in;
   logic [15:0] idle_ticks_ff, idle_ticks_in;
   logic [7:0]  reply_len_ff, reply_len_in;
   logic [7:0]  bcast_ff;
   logic [15:0] timeout_ff;

   logic [7:0]  len;
   logic [7:0]  start_sum;
   logic [7:0]  param_sum;
   logic [7:0]  params_dec;
   logic [7:0]  body_dec;
   logic [15:0] ticks_inc;
   logic        start_reply;

   assign len         = param_count + sbpe_pkg::LEN_OVERHEAD;
   assign start_sum   = target_id + len + instruction;
   assign param_sum   = sum_ff + data_byte;
   assign params_dec  = params_left_ff - 8'd1;
   assign body_dec    = body_left_ff - 8'd1;
   assign ticks_inc   = (idle_ticks_ff == sbpe_pkg::IDLE_TICKS_MAX) ?
                        idle_ticks_ff : idle_ticks_ff + 16'd1;
   assign start_reply = want_reply && (target_id != bcast_ff);

   always_comb begin
      phase_in       = phase_ff;
      sum_in         = sum_ff;
      params_left_in = params_left_ff;
      current_id_in  = current_id_ff;
      reply_exp_in   = reply_exp_ff;
      hdr_idx_in     = hdr_idx_ff;
      hdr_good_in    = hdr_good_ff;
      body_left_in   = body_left_ff;
      idle_ticks_in  = idle_ticks_ff;
      reply_len_in   = reply_len_ff;
      job            = '0;
      if (accept) begin
         unique case (mode)
            sbpe_pkg::MODE_START: begin
               current_id_in  = target_id;
               reply_exp_in   = start_reply;
               sum_in         = start_sum;
               params_left_in = param_count;
               job.hdr_en     = 1'b1;
               job.hdr_id     = target_id;
               job.hdr_len    = len;
               job.hdr_inst   = instruction;
               if (param_count == 8'd0) begin
                  job.cks_en = 1'b1;
                  job.cks    = ~start_sum;
                  if (start_reply) begin
                     phase_in      = sbpe_pkg::PH_HEADER;
                     hdr_idx_in    = 2'd0;
                     hdr_good_in   = 1'b1;
                     idle_ticks_in = 16'd0;
                  end else begin
                     job.done_en = 1'b1;
                     job.outcome = sbpe_pkg::OUTCOME_NO_REPLY;
                     phase_in    = sbpe_pkg::PH_IDLE;
                  end
               end else begin
                  phase_in = sbpe_pkg::PH_PARAMS;
               end
            end
            sbpe_pkg::MODE_PARAM: begin
               if (phase_ff == sbpe_pkg::PH_PARAMS) begin
                  job.data_en    = 1'b1;
                  job.data_kind  = sbpe_pkg::KIND_TX;
                  job.data_byte  = data_byte;
                  sum_in         = param_sum;
                  params_left_in = params_dec;
                  if (params_dec == 8'd0) begin
                     job.cks_en = 1'b1;
                     job.cks    = ~param_sum;
                     if (reply_exp_ff) begin
                        phase_in      = sbpe_pkg::PH_HEADER;
                        hdr_idx_in    = 2'd0;
                        hdr_good_in   = 1'b1;
                        idle_ticks_in = 16'd0;
                     end else begin
                        job.done_en = 1'b1;
                        job.outcome = sbpe_pkg::OUTCOME_NO_REPLY;
                        phase_in    = sbpe_pkg::PH_IDLE;
                     end
                  end
               end
            end
            sbpe_pkg::MODE_RX: begin
               if (phase_ff == sbpe_pkg::PH_HEADER) begin
                  idle_ticks_in = 16'd0;
                  if (hdr_idx_ff == 2'd3) begin
                     reply_len_in = data_byte;
                     if (!hdr_good_ff) begin
                        job.done_en   = 1'b1;
                        job.outcome   = sbpe_pkg::OUTCOME_BAD_HDR;
                        job.reply_len = data_byte;
                        phase_in      = sbpe_pkg::PH_IDLE;
                     end else if (data_byte == 8'd0) begin
                        job.done_en = 1'b1;
                        job.outcome = sbpe_pkg::OUTCOME_REPLY;
                        phase_in    = sbpe_pkg::PH_IDLE;
                     end else begin
                        body_left_in = data_byte;
                        phase_in     = sbpe_pkg::PH_BODY;
                     end
                  end else begin
                     // The first two bytes must be sync bytes, the third the id.
                     if (hdr_idx_ff == 2'd2) begin
                        if (data_byte != current_id_ff) hdr_good_in = 1'b0;
                     end else begin
                        if (data_byte != sbpe_pkg::SYNC_BYTE) hdr_good_in = 1'b0;
                     end
                     hdr_idx_in = hdr_idx_ff + 2'd1;
                  end
               end else if (phase_ff == sbpe_pkg::PH_BODY) begin
                  idle_ticks_in  = 16'd0;
                  body_left_in   = body_dec;
                  job.data_en    = 1'b1;
                  job.data_kind  = sbpe_pkg::KIND_BODY;
                  job.data_byte  = data_byte;
                  job.data_last  = (body_dec == 8'd0);
                  if (body_dec == 8'd0) begin
                     job.done_en   = 1'b1;
                     job.outcome   = sbpe_pkg::OUTCOME_REPLY;
                     job.reply_len = reply_len_ff;
                     phase_in      = sbpe_pkg::PH_IDLE;
                  end
               end
            end
            sbpe_pkg::MODE_TICK: begin
               if (phase_ff == sbpe_pkg::PH_HEADER || phase_ff == sbpe_pkg::PH_BODY) begin
                  idle_ticks_in = ticks_inc;
                  if (ticks_inc >= timeout_ff) begin
                     job.done_en   = 1'b1;
                     job.outcome   = sbpe_pkg::OUTCOME_TIMEOUT;
                     job.reply_len = (phase_ff == sbpe_pkg::PH_BODY) ? reply_len_ff : 8'd0;
                     phase_in      = sbpe_pkg::PH_IDLE;
                  end
               end
            end
            default: begin
               phase_in = phase_ff;
            end
         endcase
      end
   end

   assign push = accept && (job.hdr_en || job.data_en || job.cks_en || job.done_en);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= sbpe_pkg::PH_IDLE;
         sum_ff         <= 8'd0;
         params_left_ff <= 8'd0;
         current_id_ff  <= 8'd0;
         reply_exp_ff   <= 1'b0;
         hdr_idx_ff     <= 2'd0;
         hdr_good_ff    <= 1'b1;
         body_left_ff   <= 8'd0;
         idle_ticks_ff  <= 16'd0;
         reply_len_ff   <= 8'd0;
      end else begin
         phase_ff       <= phase_in;
         sum_ff         <= sum_in;
         params_left_ff <= params_left_in;
         current_id_ff  <= current_id_in;
         reply_exp_ff   <= reply_exp_in;
         hdr_idx_ff     <= hdr_idx_in;
         hdr_good_ff    <= hdr_good_in;
         body_left_ff   <= body_left_in;
         idle_ticks_ff  <= idle_ticks_in;
         reply_len_ff   <= reply_len_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bcast_ff   <= sbpe_pkg::BROADCAST_RESET;
         timeout_ff <= sbpe_pkg::TIMEOUT_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            sbpe_pkg::CSR_BROADCAST_ID:  bcast_ff   <= csr_wdata[7:0];
            sbpe_pkg::CSR_TIMEOUT_TICKS: timeout_ff <= csr_wdata;
            default:                     bcast_ff   <= bcast_ff;
         endcase
      end
   end

endmodule

@@ design/sbpe_queue.sv @@
// Job queue between the front end and the back end.
module sbpe_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  sbpe_pkg::job_type   push_job,
   output logic                full,
   input  logic                pop,
   output logic                head_valid,
   output sbpe_pkg::job_type   head_job
);

   sbpe_pkg::job_type                 entry_ff [sbpe_pkg::QUEUE_DEPTH];
   logic [sbpe_pkg::QUEUE_PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [sbpe_pkg::QUEUE_PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [sbpe_pkg::QUEUE_CNT_W-1:0]  count_ff, count_in;

   assign full       = (count_ff == sbpe_pkg::QUEUE_CNT_W'(sbpe_pkg::QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_job   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) count_in = count_ff + 1'b1;
      if (pop && !push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ptr_ff] <= push_job;
   end

endmodule

@@ design/sbpe_back.sv @@
// Back end: expands queued jobs into result items and holds them in the output register.
module sbpe_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                head_valid,
   input  sbpe_pkg::job_type   head_job,
   output logic                pop,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [23:0]         rsp_tdata,
   output logic                rsp_tlast,
   output logic [1:0]          rsp_tuser
);

   logic [3:0] emitted_ff, emitted_in;
   logic [2:0] hdr_idx_ff, hdr_idx_in;
   logic       valid_ff, valid_in;
   logic [1:0] kind_ff, kind_in;
   logic [7:0] byte_ff, byte_in;
   logic       last_ff, last_in;
   logic [1:0] outcome_ff, outcome_in;
   logic [7:0] rlen_ff, rlen_in;

   logic [3:0] parts;
   logic [3:0] pending;
   logic [3:0] cur_bit;
   logic       part_last;
   logic       job_last;
   logic       load;

   assign parts = {head_job.done_en, head_job.cks_en, head_job.data_en, head_job.hdr_en};
   assign pending = parts & ~emitted_ff;
   assign load = head_valid && (!valid_ff || rsp_tready);

   // The earliest pending part of the job supplies the next result item.
   always_comb begin
      cur_bit    = '0;
      part_last  = 1'b1;
      kind_in    = sbpe_pkg::KIND_TX;
      byte_in    = 8'd0;
      last_in    = 1'b0;
      outcome_in = sbpe_pkg::OUTCOME_NO_REPLY;
      rlen_in    = 8'd0;
      priority if (pending[sbpe_pkg::PART_HDR]) begin
         cur_bit[sbpe_pkg::PART_HDR] = 1'b1;
         part_last = (hdr_idx_ff == sbpe_pkg::HDR_LAST_IDX);
         unique case (hdr_idx_ff)
            3'd2:    byte_in = head_job.hdr_id;
            3'd3:    byte_in = head_job.hdr_len;
            3'd4:    byte_in = head_job.hdr_inst;
            default: byte_in = sbpe_pkg::SYNC_BYTE;
         endcase
      end else if (pending[sbpe_pkg::PART_DATA]) begin
         cur_bit[sbpe_pkg::PART_DATA] = 1'b1;
         kind_in = head_job.data_kind;
         byte_in = head_job.data_byte;
         last_in = head_job.data_last;
      end else if (pending[sbpe_pkg::PART_CKS]) begin
         cur_bit[sbpe_pkg::PART_CKS] = 1'b1;
         byte_in = head_job.cks;
         last_in = 1'b1;
      end else begin
         cur_bit[sbpe_pkg::PART_DONE] = 1'b1;
         kind_in    = sbpe_pkg::KIND_DONE;
         outcome_in = head_job.outcome;
         rlen_in    = head_job.reply_len;
      end
   end

   assign job_last = part_last && ((pending & ~cur_bit) == '0);
   assign pop      = load && job_last;

   always_comb begin
      emitted_in = emitted_ff;
      hdr_idx_in = hdr_idx_ff;
      valid_in   = valid_ff;
      if (load) begin
         valid_in = 1'b1;
         if (job_last) begin
            emitted_in = '0;
            hdr_idx_in = '0;
         end else if (part_last) begin
            emitted_in = emitted_ff | cur_bit;
         end else begin
            hdr_idx_in = hdr_idx_ff + 3'd1;
         end
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         emitted_ff <= '0;
         hdr_idx_ff <= '0;
         valid_ff   <= 1'b0;
      end else begin
         emitted_ff <= emitted_in;
         hdr_idx_ff <= hdr_idx_in;
         valid_ff   <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         kind_ff    <= kind_in;
         byte_ff    <= byte_in;
         last_ff    <= last_in;
         outcome_ff <= outcome_in;
         rlen_ff    <= rlen_in;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tuser  = kind_ff;
   assign rsp_tlast  = last_ff;
   assign rsp_tdata  = {6'd0, rlen_ff, outcome_ff, byte_ff};

   a_hdr_idx_range: assert property (@(posedge clock) disable iff (reset)
      hdr_idx_ff <= sbpe_pkg::HDR_LAST_IDX)
      else $error("header byte index ran past the instruction byte");

   a_done_no_byte: assert property (@(posedge clock) disable iff (reset)
      valid_ff && kind_ff == sbpe_pkg::KIND_DONE |-> byte_ff == 8'd0 && !last_ff)
      else $error("done item carries a byte or a last flag");

   a_byte_no_status: assert property (@(posedge clock) disable iff (reset)
      valid_ff && kind_ff != sbpe_pkg::KIND_DONE |->
         outcome_ff == sbpe_pkg::OUTCOME_NO_REPLY && rlen_ff == 8'd0)
      else $error("byte item carries status fields");

endmodule

@@ design/servo_bus_packet_engine.sv @@
// Top level of the servo bus packet engine: command frame builder and status reply receiver.
// The engine takes one input item per clock whenever its four-entry job queue has room:
// the front end classifies each item combinationally and updates the transaction state. The
// back end emits one result item per cycle while a job is queued and the output is not
// stalled by rsp_tready, so a start command yields five to seven result items (header,
// checksum when there are no parameters, done when there is also no reply), a parameter
// byte one to three, a received byte at most two and a tick at most one. Sustained
// throughput is set by the result rate of the back end; the queue absorbs the bursts a start
// command creates. The reply checksum is not checked. Registers: index 0 is the broadcast id
// (reset 254), index 1 the tick count allowed between reply bytes (reset 20); write them
// only while the engine is idle.
module servo_bus_packet_engine (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // target_id[7:0], instruction[15:8], param_count[23:16], want_reply[24],
   // data_byte[32:25], zero fill above.
   input  logic [39:0] req_tdata,
   // mode[1:0].
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // byte_value[7:0], outcome[9:8], reply_length[17:10], zero fill above.
   output logic [23:0] rsp_tdata,
   output logic        rsp_tlast,
   // kind[1:0].
   output logic [1:0]  rsp_tuser,
   input  logic        csr_wr_en,
   input  logic        csr_index,
   input  logic [15:0] csr_wdata
);

   logic              req_accept;
   logic              push;
   logic              full;
   logic              pop;
   logic              head_valid;
   sbpe_pkg::job_type push_job;
   sbpe_pkg::job_type head_job;

   assign req_tready = !full;
   assign req_accept = req_tvalid && req_tready;

   sbpe_front u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (req_accept),
      .mode        (req_tuser),
      .target_id   (req_tdata[7:0]),
      .instruction (req_tdata[15:8]),
      .param_count (req_tdata[23:16]),
      .want_reply  (req_tdata[24]),
      .data_byte   (req_tdata[32:25]),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .push        (push),
      .job         (push_job)
   );

   sbpe_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_job   (push_job),
      .full       (full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_job   (head_job)
   );

   sbpe_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_job   (head_job),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
